>>> rtl/rrol_pkg.sv
// Shared types, codes and the microcode table of the record ring offset lookup.
package rrol_pkg;

    // Step counter width and step addresses of the microprogram
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_WAIT = 3'd0;
    localparam logic [STEP_W-1:0] STEP_ADD  = 3'd2;  // dispatch base + kind 0
    localparam logic [STEP_W-1:0] STEP_INIT = 3'd3;  // dispatch base + kind 1
    localparam logic [STEP_W-1:0] STEP_SCAN = 3'd4;
    localparam logic [STEP_W-1:0] STEP_EMIT = 3'd5;

    // Datapath operations
    localparam logic [2:0] OP_WAIT = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_INIT = 3'd2;
    localparam logic [2:0] OP_SCAN = 3'd3;
    localparam logic [2:0] OP_EMIT = 3'd4;

    // Jump conditions
    localparam logic [1:0] COND_ALWAYS    = 2'd0;
    localparam logic [1:0] COND_IN_VALID  = 2'd1;
    localparam logic [1:0] COND_SCAN_DONE = 2'd2;
    localparam logic [1:0] COND_OUT_FREE  = 2'd3;

    // Request kinds
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_FIND = 1'b1;

    typedef struct packed {
        logic [2:0]        op;
        logic [1:0]        cond;
        logic              disp;     // add the request kind to the taken target
        logic [STEP_W-1:0] tgt_true;
        logic [STEP_W-1:0] tgt_false;
    } ucode_word_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic in_valid;
        logic kind;
        logic scan_done;
        logic out_free;
    } seq_stat_t;

    // Control from the sequencer to the datapath
    typedef struct packed {
        logic [2:0] op;
    } seq_ctrl_t;

    function automatic ucode_word_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_word_t w;
        case (step)
            STEP_WAIT: w = '{OP_WAIT, COND_IN_VALID,  1'b1, STEP_ADD,  STEP_WAIT};
            STEP_ADD:  w = '{OP_ADD,  COND_ALWAYS,    1'b0, STEP_EMIT, STEP_EMIT};
            STEP_INIT: w = '{OP_INIT, COND_ALWAYS,    1'b0, STEP_SCAN, STEP_SCAN};
            STEP_SCAN: w = '{OP_SCAN, COND_SCAN_DONE, 1'b0, STEP_EMIT, STEP_SCAN};
            STEP_EMIT: w = '{OP_EMIT, COND_OUT_FREE,  1'b0, STEP_WAIT, STEP_EMIT};
            default:   w = '{OP_WAIT, COND_ALWAYS,    1'b0, STEP_WAIT, STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/rrol_seq.sv
// Microcode sequencer: step counter, control table fetch and conditional jumps.
module rrol_seq
    import rrol_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  seq_stat_t stat,
    output seq_ctrl_t ctrl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ucode_word_t       word;
    logic              met;

    always_comb begin
        word = ucode_rom(step_reg);
        case (word.cond)
            COND_ALWAYS:    met = 1'b1;
            COND_IN_VALID:  met = stat.in_valid;
            COND_SCAN_DONE: met = stat.scan_done;
            COND_OUT_FREE:  met = stat.out_free;
            default:        met = 1'b1;
        endcase
        if (met) begin
            step_next = word.disp ? (word.tgt_true | {{(STEP_W-1){1'b0}}, stat.kind})
                                  : word.tgt_true;
        end else begin
            step_next = word.tgt_false;
        end
        ctrl.op = word.op;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

>>> rtl/record_ring_offset_lookup_core.sv
// Top level of the record ring offset lookup: ring storage, scan datapath, stream ports.
//
// Keeps a ring of DEPTH records (32-bit handle, 16-bit byte size). An add request
// (s_tuser = 0) stores a record at the write slot and overwrites the oldest one
// when the ring is full; a zero-size add changes nothing. A find request
// (s_tuser = 1) treats the stored records, oldest first, as one byte string and
// returns the record that holds the requested byte offset and the byte position
// inside it.
// Every request yields exactly one result; adds and misses return all zeros.
// A small microcoded sequencer steps the datapath. After acceptance an add runs
// the ADD and EMIT steps. A find runs INIT, then stays in SCAN while it passes
// over the records before the hit (at most the stored count), then runs EMIT:
// the scan reads one record size per cycle from the single read port of the
// record memory. A finished result sits in the output register while the next
// request is accepted and worked on; the sequencer only holds in its final step
// if that result has not been taken yet.
// The record memory needs no clearing: a find reads stored records only.
module record_ring_offset_lookup_core
    import rrol_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, from bit 0: entry_handle[31:0], entry_size[47:32],
    // byte_offset[67:48], zero fill [71:68]
    input  logic [71:0] s_tdata,
    // s_tuser: kind (0 = add record, 1 = find byte offset)
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, from bit 0: result_handle[31:0], byte_in_entry[47:32]
    output logic [47:0] m_tdata,
    // m_tuser: found
    output logic        m_tuser
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    seq_stat_t stat;
    seq_ctrl_t ctrl;

    rrol_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    // Latched request
    logic        kind_reg;
    logic [31:0] handle_reg;
    logic [15:0] size_reg;
    logic [19:0] offset_reg;

    // Ring pointers
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             full_reg, full_next;

    // Scan state
    logic [IDX_W-1:0] scan_ptr_reg, scan_ptr_next;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic [19:0]      remain_reg, remain_next;

    // Result being built
    logic        found_reg, found_next;
    logic [31:0] res_handle_reg, res_handle_next;
    logic [15:0] res_byte_reg, res_byte_next;

    // Output register
    logic        m_valid_reg;
    logic        m_found_reg;
    logic [31:0] m_handle_reg;
    logic [15:0] m_byte_reg;

    // Record memory, read data registered
    logic [31:0] handle_mem [DEPTH];
    logic [15:0] size_mem   [DEPTH];
    logic [31:0] handle_q;
    logic [15:0] size_q;

    logic             in_fire;
    logic             out_free;
    logic             hit;
    logic [CNT_W-1:0] stored_cnt;
    logic [IDX_W-1:0] wr_idx_inc;
    logic [IDX_W-1:0] scan_ptr_inc;

    assign s_tready = (ctrl.op == OP_WAIT);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign hit      = (scan_cnt_reg != '0) && ({4'b0, size_q} > remain_reg);

    assign stat.in_valid  = s_tvalid;
    assign stat.kind      = s_tuser;
    assign stat.scan_done = (scan_cnt_reg == '0) || hit;
    assign stat.out_free  = out_free;

    assign wr_idx_inc   = (wr_idx_reg == LAST_SLOT) ? '0 : wr_idx_reg + 1'b1;
    assign scan_ptr_inc = (scan_ptr_reg == LAST_SLOT) ? '0 : scan_ptr_reg + 1'b1;

    // Stored record count from the ring pointers
    always_comb begin
        if (full_reg) begin
            stored_cnt = FULL_CNT;
        end else if (wr_idx_reg >= rd_idx_reg) begin
            stored_cnt = CNT_W'(wr_idx_reg - rd_idx_reg);
        end else begin
            stored_cnt = CNT_W'({1'b0, wr_idx_reg} + (IDX_W + 1)'(DEPTH)
                                - {1'b0, rd_idx_reg});
        end
    end

    always_comb begin
        wr_idx_next     = wr_idx_reg;
        rd_idx_next     = rd_idx_reg;
        full_next       = full_reg;
        scan_ptr_next   = scan_ptr_reg;
        scan_cnt_next   = scan_cnt_reg;
        remain_next     = remain_reg;
        found_next      = found_reg;
        res_handle_next = res_handle_reg;
        res_byte_next   = res_byte_reg;
        case (ctrl.op)
            OP_ADD: begin
                // Clear the result; store only non-empty records
                found_next      = 1'b0;
                res_handle_next = '0;
                res_byte_next   = '0;
                if (size_reg != '0) begin
                    wr_idx_next = wr_idx_inc;
                    if (full_reg) begin
                        rd_idx_next = wr_idx_inc;
                    end else if (wr_idx_inc == rd_idx_reg) begin
                        full_next = 1'b1;
                    end
                end
            end
            OP_INIT: begin
                // Start at the oldest record; memory fetches its size this edge
                found_next      = 1'b0;
                res_handle_next = '0;
                res_byte_next   = '0;
                scan_ptr_next   = rd_idx_reg;
                scan_cnt_next   = stored_cnt;
                remain_next     = offset_reg;
            end
            OP_SCAN: begin
                if (hit) begin
                    found_next      = 1'b1;
                    res_handle_next = handle_q;
                    res_byte_next   = remain_reg[15:0];
                end else if (scan_cnt_reg != '0) begin
                    // Skip this record and advance to the next slot
                    remain_next   = remain_reg - {4'b0, size_q};
                    scan_ptr_next = scan_ptr_inc;
                    scan_cnt_next = scan_cnt_reg - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.op == OP_ADD && size_reg != '0) begin
            handle_mem[wr_idx_reg] <= handle_reg;
            size_mem[wr_idx_reg]   <= size_reg;
        end
        handle_q <= handle_mem[scan_ptr_next];
        size_q   <= size_mem[scan_ptr_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg  <= '0;
            rd_idx_reg  <= '0;
            full_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            full_reg   <= full_next;
            if (ctrl.op == OP_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            kind_reg   <= s_tuser;
            handle_reg <= s_tdata[31:0];
            size_reg   <= s_tdata[47:32];
            offset_reg <= s_tdata[67:48];
        end
        scan_ptr_reg   <= scan_ptr_next;
        scan_cnt_reg   <= scan_cnt_next;
        remain_reg     <= remain_next;
        found_reg      <= found_next;
        res_handle_reg <= res_handle_next;
        res_byte_reg   <= res_byte_next;
        if (ctrl.op == OP_EMIT && out_free) begin
            // Hold the result for the consumer; add results are all zero
            m_found_reg  <= found_reg && (kind_reg == KIND_FIND);
            m_handle_reg <= (kind_reg == KIND_FIND) ? res_handle_reg : '0;
            m_byte_reg   <= (kind_reg == KIND_FIND) ? res_byte_reg : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {m_byte_reg, m_handle_reg};

endmodule
